### hw/rtl/b64u_pkg.sv
package b64u_pkg;

  localparam int          LIMIT_W       = 12;
  localparam int          SLOTS         = 4;
  localparam logic [6:0]  PAD_CHAR      = 7'd46;   // '.'
  localparam logic [11:0] MAX_CHARS_RST = 12'd4095;

  // Position of the next byte in its 3-byte group
  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_t;

  typedef struct packed {
    logic [6:0] chr;
    logic       eor;
    logic       ovf;
  } res_t;

  // Up to four results produced by one input byte
  typedef struct packed {
    res_t [SLOTS-1:0] slot;
    logic [2:0]       n;
  } job_t;

  // URL-safe alphabet: A-Z a-z 0-9 - _
  function automatic logic [6:0] b64u_char(input logic [5:0] v);
    logic [6:0] c;
    case (v) inside
      [6'd0 : 6'd25]:  c = 7'd65 + {1'b0, v};
      [6'd26 : 6'd51]: c = 7'd71 + {1'b0, v};
      [6'd52 : 6'd61]: c = {1'b0, v} - 7'd4;
      6'd62:           c = 7'd45;
      default:         c = 7'd95;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/b64u_in_if.sv
interface b64u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

### hw/rtl/b64u_out_if.sv
interface b64u_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_run;
  logic       overflow;

  modport source (output valid, out_char, end_of_run, overflow, input ready);
  modport sink   (input valid, out_char, end_of_run, overflow, output ready);
endinterface

### hw/rtl/b64u_encode.sv
module b64u_encode #(
  parameter int COUNT_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       xfer,
  input  logic [7:0]                 data_byte,
  input  logic                       final_byte,
  input  logic [b64u_pkg::LIMIT_W-1:0] max_chars,
  output b64u_pkg::job_t             job
);
  import b64u_pkg::*;

  localparam int CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic [3:0]            carry_r, carry_nxt;
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  failed_r, failed_nxt;

  logic [3:0]            carry_upd;
  phase_t                phase_upd;
  logic [SLOTS-1:0][6:0] code;
  logic [2:0]            want, fit, total;
  logic                  ovf;
  logic [CW-1:0]         lim_w, cnt_w, cap_w, room;
  logic [CW:0]           sum;
  logic [COUNT_BITS-1:0] count_upd;

  always_comb begin
    code = {SLOTS{PAD_CHAR}};
    case (phase_r)
      PH_B: begin
        code[0]   = b64u_char({carry_r[1:0], data_byte[7:4]});
        code[1]   = b64u_char({data_byte[3:0], 2'b00});
        want      = final_byte ? 3'd3 : 3'd1;
        carry_upd = data_byte[3:0];
        phase_upd = PH_C;
      end
      PH_C: begin
        code[0]   = b64u_char({carry_r, data_byte[7:6]});
        code[1]   = b64u_char(data_byte[5:0]);
        want      = 3'd2;
        carry_upd = 4'd0;
        phase_upd = PH_A;
      end
      default: begin  // phase 0, and the unused code 3
        code[0]   = b64u_char(data_byte[7:2]);
        code[1]   = b64u_char({data_byte[1:0], 4'b0000});
        want      = final_byte ? 3'd4 : 3'd1;
        carry_upd = {2'b00, data_byte[1:0]};
        phase_upd = PH_B;
      end
    endcase

    // how many characters fit under the limit
    cap_w = CW'({COUNT_BITS{1'b1}});
    lim_w = CW'(max_chars);
    cnt_w = CW'(count_r);
    room  = lim_w - cnt_w;
    if (lim_w > cap_w) begin
      fit = want;               // saturating counter never reaches the limit
    end else if (cnt_w >= lim_w) begin
      fit = 3'd0;
    end else if (room < CW'(want)) begin
      fit = room[2:0];
    end else begin
      fit = want;
    end
    ovf   = (fit != want);
    total = failed_r ? 3'd0 : (ovf ? fit + 3'd1 : want);

    for (int i = 0; i < SLOTS; i++) begin
      job.slot[i].ovf = ovf && (3'(i) == fit);
      job.slot[i].chr = job.slot[i].ovf ? 7'd0 : code[i];
      job.slot[i].eor = (3'(i) == total - 3'd1);
    end
    job.n = total;

    sum = {1'b0, cnt_w} + (CW+1)'(fit);
    if (sum > {1'b0, cap_w}) begin
      count_upd = '1;
    end else begin
      count_upd = sum[COUNT_BITS-1:0];
    end

    carry_nxt  = carry_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    if (xfer) begin
      if (final_byte) begin
        carry_nxt  = 4'd0;
        phase_nxt  = PH_A;
        count_nxt  = '0;
        failed_nxt = 1'b0;
      end else if (!failed_r) begin
        carry_nxt  = carry_upd;
        phase_nxt  = phase_upd;
        count_nxt  = count_upd;
        failed_nxt = ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r  <= 4'd0;
      phase_r  <= PH_A;
      count_r  <= '0;
      failed_r <= 1'b0;
    end else begin
      carry_r  <= carry_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && final_byte |=> carry_r == 4'd0 && phase_r == PH_A && count_r == '0 && !failed_r)
    else $error("message end did not clear encoder state");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> job.n == 3'd0)
    else $error("results produced while discarding a failed message");

  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    job.n <= 3'(SLOTS))
    else $error("job holds more than four results");

endmodule

### hw/rtl/b64u_serializer.sv
module b64u_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  b64u_pkg::job_t job,
  output logic           can_load,
  b64u_out_if.source     out_ch
);
  import b64u_pkg::*;

  res_t [SLOTS-1:0] slot_r, slot_nxt;
  logic [2:0]       rem_r, rem_nxt;
  logic             out_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;
  // free now, or the last result leaves this cycle
  assign can_load = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ch.ready);

  always_comb begin
    slot_nxt = slot_r;
    rem_nxt  = rem_r;
    if (load) begin
      slot_nxt = job.slot;
      rem_nxt  = job.n;
    end else if (out_xfer) begin
      slot_nxt = {res_t'('0), slot_r[SLOTS-1:1]};
      rem_nxt  = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign out_ch.valid      = (rem_r != 3'd0);
  assign out_ch.out_char   = slot_r[0].chr;
  assign out_ch.end_of_run = slot_r[0].eor;
  assign out_ch.overflow   = slot_r[0].ovf;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'(SLOTS))
    else $error("result count out of range");

  a_ovf_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |-> out_ch.end_of_run && out_ch.out_char == 7'd0)
    else $error("overflow result is not the last of its run");

  a_last_then_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_ch.end_of_run && !load |=> rem_r == 3'd0)
    else $error("results left after end of run");

endmodule

### hw/rtl/base64url_stream_encoder.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   data_byte[7:0], final_byte
// out_ch    out  valid/ready   out_char[6:0], end_of_run, overflow
// cfg_*     in   cfg_we        cfg_wdata[11:0] -> max_chars
//
// The result buffer sends one result per cycle while out_ch is ready. An input
// byte yields 1 or 2 results (2 for the third byte of a group), up to 4 at
// message end; a byte of a failed message yields none.
// Reset (rst_n low, synchronous) clears encoder state and sets max_chars to 4095.
// A stalled out_ch holds the buffer; in_ch is taken again once the last buffered
// result transfers, in the same cycle.
module base64url_stream_encoder #(
  parameter int COUNT_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  b64u_in_if.sink                      in_ch,
  b64u_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [b64u_pkg::LIMIT_W-1:0] cfg_wdata
);
  import b64u_pkg::*;

  logic [LIMIT_W-1:0] max_chars_r;
  logic               in_xfer;
  logic               can_load;
  job_t               job;

  // limit register; the user must write it only between messages' traffic, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RST;
    end else if (cfg_we) begin
      max_chars_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // state update and character selection for the byte in transfer
  b64u_encode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer       (in_xfer),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .max_chars  (max_chars_r),
    .job        (job)
  );

  // result buffer; bytes of a failed message load nothing
  b64u_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_xfer && (job.n != 3'd0)),
    .job      (job),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_accept_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !out_ch.valid || (out_ch.ready && out_ch.end_of_run))
    else $error("input taken while buffered results remain");

  a_cfg_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) |-> $stable(max_chars_r))
    else $error("limit changed without a write");

  a_cfg_takes: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> max_chars_r == $past(cfg_wdata))
    else $error("limit write lost");

endmodule

### dv/tb_base64url_stream_encoder.sv
`timescale 1ns / 1ps

module tb_base64url_stream_encoder;
  import b64u_pkg::*;

  localparam int COUNT_BITS     = 12;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either channel
  localparam int LONG_HOLD      = 60;    // one long receiver stall, fills the result buffer
  localparam int DRAIN_CYCLES   = 16;    // tail after the last expected result
  localparam int CFG_SETTLE     = 8;     // covers discarded bytes still in flight
  localparam int HOLD_MSG_LEN   = 12;    // message sent while the receiver holds off

  // 64 ASCII codes, index 0 in the top byte
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // One row of the directed table. With fixed set, the expected results are read
  // off the row: nchars characters of txt (rightmost char last), then an overflow
  // result if ovf is set. Without it, the encoder model supplies them.
  typedef struct packed {
    logic        lim_we;   // write max_chars (idle block) before this byte
    logic [11:0] lim;
    logic [7:0]  data;
    logic        fin;
    logic        fixed;
    logic [2:0]  nchars;
    logic [31:0] txt;
    logic        ovf;
  } dir_row_t;

  localparam int DIR_ROWS_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // right after reset: one-byte messages at the data extremes
    '{1'b0, 12'd0,    8'h00, 1'b1, 1'b1, 3'd4, "AA..",  1'b0},
    '{1'b0, 12'd0,    8'hFF, 1'b1, 1'b1, 3'd4, "_w..",  1'b0},
    // '-' and '_' codes, then a final byte in the third group position
    '{1'b0, 12'd0,    8'hFB, 1'b0, 1'b1, 3'd1, "-",     1'b0},
    '{1'b0, 12'd0,    8'hEF, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'hBF, 1'b1, 1'b0, 3'd0, 32'h0,   1'b0},
    // longer message, ends in the second group position (one pad)
    '{1'b0, 12'd0,    8'h4D, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h61, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h6E, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h12, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h34, 1'b1, 1'b0, 3'd0, 32'h0,   1'b0},
    // full group, then a final byte opening a new group (two pads)
    '{1'b0, 12'd0,    8'h00, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'hFF, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'hAA, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h55, 1'b1, 1'b0, 3'd0, 32'h0,   1'b0},
    // zero limit: overflow on the first char, discard until final
    '{1'b1, 12'd0,    8'h41, 1'b0, 1'b1, 3'd0, 32'h0,   1'b1},
    '{1'b0, 12'd0,    8'h42, 1'b0, 1'b1, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h43, 1'b1, 1'b1, 3'd0, 32'h0,   1'b0},
    // zero limit on a final byte: overflow and clear at once
    '{1'b0, 12'd0,    8'h44, 1'b1, 1'b1, 3'd0, 32'h0,   1'b1},
    // chars that fit are still sent before the overflow
    '{1'b1, 12'd2,    8'h00, 1'b1, 1'b1, 3'd2, "AA",    1'b1},
    '{1'b1, 12'd3,    8'h00, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h00, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'h00, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b0, 12'd0,    8'hFF, 1'b1, 1'b1, 3'd0, 32'h0,   1'b0},
    // limit lowered in the middle of a message
    '{1'b1, 12'd4095, 8'h00, 1'b0, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b1, 12'd1,    8'h00, 1'b1, 1'b0, 3'd0, 32'h0,   1'b0},
    '{1'b1, 12'd4095, 8'hFF, 1'b1, 1'b1, 3'd4, "_w..",  1'b0}
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [11:0] cfg_wdata;

  b64u_in_if  in_ch ();
  b64u_out_if out_ch ();

  base64url_stream_encoder #(
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Encoder model state, mirrors the block
  logic [11:0]           max_lim;
  logic [3:0]            carry_nib;
  phase_t                grp_pos;
  logic [COUNT_BITS-1:0] char_cnt;
  bit                    msg_failed;

  // Results of the last modeled byte
  res_t step_res [4];
  int   step_n;

  res_t pending_chars [$];   // expected results, oldest first
  res_t got_res;
  res_t want_res;
  int   fail_count   = 0;
  int   quiet_cycles = 0;

  // Traffic shaping, set by the stimulus, read by both channel drivers
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [6:0] url_char(input logic [5:0] v);
    return URL_ALPHABET[8*(63-v) +: 7];
  endfunction

  function automatic void clear_msg();
    carry_nib  = '0;
    grp_pos    = PH_A;
    char_cnt   = '0;
    msg_failed = 1'b0;
  endfunction

  // Model of one accepted byte: fills step_res/step_n and advances the state.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [6:0] want [4];
    int         nwant;
    int         i;
    bit         hit_limit;
    step_n    = 0;
    nwant     = 0;
    hit_limit = 1'b0;
    if (msg_failed) begin
      // dropped silently until the final byte
      if (fin) clear_msg();
      return;
    end
    case (grp_pos)
      PH_B: begin
        want[0]   = url_char({carry_nib[1:0], b[7:4]});
        carry_nib = b[3:0];
        grp_pos   = PH_C;
        nwant     = 1;
        if (fin) begin
          want[1] = url_char({carry_nib, 2'b00});
          want[2] = PAD_CHAR;
          nwant   = 3;
        end
      end
      PH_C: begin
        want[0]   = url_char({carry_nib, b[7:6]});
        want[1]   = url_char(b[5:0]);
        carry_nib = '0;
        grp_pos   = PH_A;
        nwant     = 2;
      end
      default: begin
        // phase 3 is unreachable and decodes as the first position
        want[0]   = url_char(b[7:2]);
        carry_nib = {2'b00, b[1:0]};
        grp_pos   = PH_B;
        nwant     = 1;
        if (fin) begin
          want[1] = url_char({b[1:0], 4'b0000});
          want[2] = PAD_CHAR;
          want[3] = PAD_CHAR;
          nwant   = 4;
        end
      end
    endcase
    for (i = 0; i < nwant && !hit_limit; i++) begin
      if (char_cnt >= max_lim) begin
        hit_limit = 1'b1;
      end else begin
        step_res[step_n] = res_t'{want[i], 1'b0, 1'b0};
        step_n++;
        if (char_cnt != '1) char_cnt++;   // counter saturates
      end
    end
    if (hit_limit) begin
      step_res[step_n] = res_t'{7'd0, 1'b1, 1'b1};
      step_n++;
      if (fin) clear_msg();
      else     msg_failed = 1'b1;
    end else begin
      step_res[step_n-1].eor = 1'b1;
      if (fin) clear_msg();
    end
  endfunction

  // Offer one byte; on its transfer queue up what it should produce. Starts and
  // ends at a falling edge. valid is left high so back-to-back bytes never see
  // it dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] b, input logic fin, input dir_row_t fixed_exp);
    int k;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_byte(b, fin);
    if (fixed_exp.fixed) begin
      for (k = 0; k < fixed_exp.nchars; k++)
        pending_chars.push_back(res_t'{fixed_exp.txt[8*(fixed_exp.nchars-1-k) +: 7],
                                       (k == fixed_exp.nchars - 1) && !fixed_exp.ovf,
                                       1'b0});
      if (fixed_exp.ovf) pending_chars.push_back(res_t'{7'd0, 1'b1, 1'b1});
    end else begin
      for (k = 0; k < step_n; k++) pending_chars.push_back(step_res[k]);
    end
    @(negedge clk);
  endtask

  // max_chars is only touched with the block idle: all results drained, plus the
  // CFG_SETTLE wait for bytes of a failed message that produce nothing.
  task automatic set_limit(input logic [11:0] v);
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    max_lim   = v;
  endtask

  // Random well-formed messages: mostly short, a few long; limit re-picked now
  // and then so overflow shows up at many points of a message.
  task automatic send_messages(input int budget);
    int          sent;
    int          len;
    int          k;
    logic [11:0] lim;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0:       lim = 12'($urandom_range(8));
          1:       lim = 12'($urandom_range(48, 9));
          2:       lim = 12'hFFF;
          default: lim = 12'($urandom_range(4095));
        endcase
        set_limit(lim);
      end
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (k = 0; k < len; k++)
        send_byte(8'($urandom_range(255)), k == len - 1, '0);
      sent += len;
    end
  endtask

  // Receiver: random back-pressure, plus one long stall on request
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Scoreboard: every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res = res_t'{out_ch.out_char, out_ch.end_of_run, out_ch.overflow};
      if (pending_chars.size() == 0) begin
        $error("unexpected result: out_char %0d end_of_run %0b overflow %0b",
               got_res.chr, got_res.eor, got_res.ovf);
        fail_count++;
      end else begin
        want_res = pending_chars.pop_front();
        if (got_res.chr !== want_res.chr) begin
          $error("out_char: expected %0d, got %0d", want_res.chr, got_res.chr);
          fail_count++;
        end
        if (got_res.eor !== want_res.eor) begin
          $error("end_of_run: expected %0b, got %0b", want_res.eor, got_res.eor);
          fail_count++;
        end
        if (got_res.ovf !== want_res.ovf) begin
          $error("overflow: expected %0b, got %0b", want_res.ovf, got_res.ovf);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    max_lim          = MAX_CHARS_RST;
    clear_msg();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, no idling on either side
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].lim_we) set_limit(DIR_ROWS[r].lim);
      send_byte(DIR_ROWS[r].data, DIR_ROWS[r].fin, DIR_ROWS[r]);
    end

    // Random messages under three idling mixes
    tx_idle_pct = 18;
    rx_idle_pct = 71;
    send_messages(100);

    tx_idle_pct = 71;
    rx_idle_pct = 18;
    send_messages(100);

    // Full rate; the receiver stalls once for a long stretch while bytes keep
    // coming, so the result buffer fills and in_ch backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    for (k = 0; k < HOLD_MSG_LEN; k++)
      send_byte(8'($urandom_range(255)), k == HOLD_MSG_LEN - 1, '0);
    send_messages(100);

    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/b64u_pkg.sv
hw/rtl/b64u_in_if.sv
hw/rtl/b64u_out_if.sv
hw/rtl/b64u_encode.sv
hw/rtl/b64u_serializer.sv
hw/rtl/base64url_stream_encoder.sv
dv/tb_base64url_stream_encoder.sv
